@@ sv/urtf_pkg.sv @@
// ----------------------------------------------------------------------------
// urtf_pkg
// Shared constants and types for the UART receive/transmit ring FIFO block.
// ----------------------------------------------------------------------------
package urtf_pkg;

  // default number of slots per ring (one slot always stays free)
  localparam int unsigned RING_DEPTH_DFLT = 64;

  // payload widths
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned LEVEL_W = 6;

  // event codes
  localparam logic [CMD_W-1:0] CMD_RX_BYTE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HOST_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HOST_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HOST_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TX_READY   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd5;

  // status codes
  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_RX_DROP = 2'd1;
  localparam logic [STS_W-1:0] STS_TX_FULL = 2'd2;
  localparam logic [STS_W-1:0] STS_EMPTY   = 2'd3;

  // control of one ring for one transaction
  typedef struct packed {
    logic              push;
    logic              pop;
    logic              rd_en;
    logic              flush;
    logic [BYTE_W-1:0] wdata;
  } ring_ctl_t;

  // status of one ring
  typedef struct packed {
    logic               empty;
    logic               full;
    logic [LEVEL_W-1:0] level;
  } ring_sts_t;

endpackage

@@ sv/urtf_if.sv @@
// ----------------------------------------------------------------------------
// urtf_if
// Valid/ready channels for events into and results out of the ring FIFOs.
// ----------------------------------------------------------------------------
interface urtf_req_if;
  import urtf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] data_in;

  modport source (output valid, output cmd, output data_in, input ready);
  modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

interface urtf_rsp_if;
  import urtf_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  data_out;
  logic               data_valid;
  logic [STS_W-1:0]   status;
  logic [LEVEL_W-1:0] rx_level;
  logic [LEVEL_W-1:0] tx_level;
  logic               tx_irq_enabled;

  modport source (output valid, output data_out, output data_valid, output status,
                  output rx_level, output tx_level, output tx_irq_enabled,
                  input ready);
  modport sink   (input valid, input data_out, input data_valid, input status,
                  input rx_level, input tx_level, input tx_irq_enabled,
                  output ready);
endinterface

@@ sv/uart_rx_tx_ring_fifo.sv @@
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_fifo
// Receive and transmit ring FIFOs of one UART channel, one event per transaction.
// ----------------------------------------------------------------------------
// Usage: each event on req_i (cmd, data_in) gives exactly one result on rsp_o.
// Events: byte received, host read, host peek, host write, transmitter ready
// and flush of the receive ring. Results carry the byte read (data_out,
// data_valid), a status code and both fill levels plus the transmit
// interrupt enable as they stand after the event.
// The event is decoded and the rings updated at the accepting edge, and the
// result sits in the output register in the following cycle.
// Throughput is one event per cycle while rsp_o.ready stays high; each ring
// has a single read port with registered read data.
// req_i.ready is high while the output register is empty or being taken, so
// a stalled receiver holds the result and blocks further events.
// Reset clears the pointers and the interrupt enable; the ring stores are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_fifo #(
  parameter int unsigned RING_DEPTH = urtf_pkg::RING_DEPTH_DFLT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  urtf_req_if.sink   req_i,
  urtf_rsp_if.source rsp_o
);
  import urtf_pkg::*;

  ring_ctl_t        rx_ctl, tx_ctl;
  ring_sts_t        rx_sts, tx_sts;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  logic             accept;
  logic             out_vld_q;
  logic             dvalid_d, dvalid_q;
  logic             sel_tx_d, sel_tx_q;
  logic [STS_W-1:0] status_d, status_q;
  logic             irq_d, irq_q;

  assign req_i.ready = !out_vld_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // event decode
  always_comb begin
    rx_ctl       = '0;
    tx_ctl       = '0;
    rx_ctl.wdata = req_i.data_in;
    tx_ctl.wdata = req_i.data_in;
    dvalid_d     = 1'b0;
    sel_tx_d     = 1'b0;
    status_d     = STS_OK;
    irq_d        = irq_q;
    if (accept) begin
      unique case (req_i.cmd) inside
        CMD_RX_BYTE: begin
          if (rx_sts.full) status_d = STS_RX_DROP;
          else rx_ctl.push = 1'b1;
        end
        CMD_HOST_READ, CMD_HOST_PEEK: begin
          if (rx_sts.empty) begin
            status_d = STS_EMPTY;
          end else begin
            dvalid_d     = 1'b1;
            rx_ctl.rd_en = 1'b1;
            rx_ctl.pop   = (req_i.cmd == CMD_HOST_READ);
          end
        end
        CMD_HOST_WRITE: begin
          if (tx_sts.full) begin
            status_d = STS_TX_FULL;
          end else begin
            tx_ctl.push = 1'b1;
            irq_d       = 1'b1;
          end
        end
        CMD_TX_READY: begin
          if (tx_sts.empty) begin
            irq_d    = 1'b0;
            status_d = STS_EMPTY;
          end else begin
            dvalid_d     = 1'b1;
            sel_tx_d     = 1'b1;
            tx_ctl.rd_en = 1'b1;
            tx_ctl.pop   = 1'b1;
          end
        end
        CMD_FLUSH: rx_ctl.flush = 1'b1;
        default: ;
      endcase
    end
  end

  urtf_ring #(.DEPTH(RING_DEPTH)) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (rx_ctl),
    .sts_o   (rx_sts),
    .rdata_o (rx_rdata)
  );

  urtf_ring #(.DEPTH(RING_DEPTH)) u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (tx_ctl),
    .sts_o   (tx_sts),
    .rdata_o (tx_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      irq_q     <= 1'b0;
    end else begin
      irq_q <= irq_d;
      if (accept) out_vld_q <= 1'b1;
      else if (rsp_o.ready) out_vld_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dvalid_q <= dvalid_d;
      sel_tx_q <= sel_tx_d;
      status_q <= status_d;
    end
  end

  // result drive; levels and enable are state that only moves on accept
  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.data_out       = dvalid_q ? (sel_tx_q ? tx_rdata : rx_rdata) : '0;
  assign rsp_o.data_valid     = dvalid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.rx_level       = rx_sts.level;
  assign rsp_o.tx_level       = tx_sts.level;
  assign rsp_o.tx_irq_enabled = irq_q;

endmodule

@@ sv/urtf_ring.sv @@
// ----------------------------------------------------------------------------
// urtf_ring
// One ring FIFO: byte store, head and tail pointers, registered read port.
// ----------------------------------------------------------------------------
module urtf_ring #(
  parameter int unsigned DEPTH = urtf_pkg::RING_DEPTH_DFLT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  urtf_pkg::ring_ctl_t          ctl_i,
  output urtf_pkg::ring_sts_t          sts_o,
  output logic [urtf_pkg::BYTE_W-1:0]  rdata_o
);
  import urtf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(DEPTH);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic [PTR_W-1:0]  head_q, head_d, head_nxt;
  logic [PTR_W-1:0]  tail_q, tail_d, tail_nxt;
  logic [PTR_W:0]    level;

  // wrap-around increment
  assign head_nxt = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

  // pointer update
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctl_i.flush) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (ctl_i.push) head_d = head_nxt;
      if (ctl_i.pop)  tail_d = tail_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // byte store, written at head, read at tail
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem_q[head_q] <= ctl_i.wdata;
    if (ctl_i.rd_en) rdata_q <= mem_q[tail_q];
  end

  // fill level of the current pointers
  assign level = {1'b0, head_q} + ((head_q < tail_q) ? DEPTH_EXT : '0)
                 - {1'b0, tail_q};

  assign sts_o.empty = (head_q == tail_q);
  assign sts_o.full  = (head_nxt == tail_q);
  assign sts_o.level = LEVEL_W'(level);
  assign rdata_o     = rdata_q;

endmodule

@@ dv/uart_rx_tx_ring_fifo_tb.sv @@
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_fifo_tb
// Self-checking bench for the UART receive/transmit ring FIFOs. A queue of
// events (a directed opening, then fill, drain and mixed phases with random
// bytes) feeds a valid/ready driver. A monitor with random back-pressure
// compares every result field by field with a ring model kept in the bench.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import urtf_pkg::*;

  localparam int unsigned DEPTH        = RING_DEPTH_DFLT;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  // codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef enum int unsigned {
    SEG_RX_FILL,
    SEG_RX_DRAIN,
    SEG_TX_FILL,
    SEG_TX_DRAIN,
    SEG_MIXED
  } seg_mode_e;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
    int unsigned       gap;
  } ring_event_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_out;
    logic               data_valid;
    logic [STS_W-1:0]   status;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               tx_irq_enabled;
  } ring_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  urtf_req_if req ();
  urtf_rsp_if rsp ();

  uart_rx_tx_ring_fifo #(
    .RING_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bench copy of both rings
  logic [BYTE_W-1:0] rx_bytes [DEPTH];
  logic [BYTE_W-1:0] tx_bytes [DEPTH];
  int unsigned       rx_wr_idx, rx_rd_idx, tx_wr_idx, tx_rd_idx;
  logic              irq_en;

  ring_event_t  pending_events [$];
  ring_result_t awaited_results [$];

  int unsigned errors       = 0;
  int unsigned accepted     = 0;
  int unsigned total_events = 0;
  int unsigned results_seen = 0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  bit          rsp_quiet    = 1'b0;
  int unsigned cycles       = 0;

  // apply one event to the bench rings and give the result it produces
  function automatic ring_result_t ring_event_outcome(logic [CMD_W-1:0] cmd,
                                                      logic [BYTE_W-1:0] din);
    ring_result_t r;
    int unsigned  nxt;
    r = '0;
    r.status = STS_OK;
    case (cmd)
      CMD_RX_BYTE: begin
        nxt = (rx_wr_idx + 1) % DEPTH;
        if (nxt != rx_rd_idx) begin
          rx_bytes[rx_wr_idx] = din;
          rx_wr_idx = nxt;
        end else begin
          r.status = STS_RX_DROP;
        end
      end
      CMD_HOST_READ, CMD_HOST_PEEK: begin
        if (rx_wr_idx == rx_rd_idx) begin
          r.status = STS_EMPTY;
        end else begin
          r.data_out   = rx_bytes[rx_rd_idx];
          r.data_valid = 1'b1;
          if (cmd == CMD_HOST_READ) rx_rd_idx = (rx_rd_idx + 1) % DEPTH;
        end
      end
      CMD_HOST_WRITE: begin
        nxt = (tx_wr_idx + 1) % DEPTH;
        if (nxt != tx_rd_idx) begin
          tx_bytes[tx_wr_idx] = din;
          tx_wr_idx = nxt;
          irq_en = 1'b1;
        end else begin
          r.status = STS_TX_FULL;
        end
      end
      CMD_TX_READY: begin
        if (tx_wr_idx == tx_rd_idx) begin
          irq_en   = 1'b0;
          r.status = STS_EMPTY;
        end else begin
          r.data_out   = tx_bytes[tx_rd_idx];
          r.data_valid = 1'b1;
          tx_rd_idx = (tx_rd_idx + 1) % DEPTH;
        end
      end
      CMD_FLUSH: begin
        foreach (rx_bytes[i]) rx_bytes[i] = '0;
        rx_wr_idx = 0;
        rx_rd_idx = 0;
      end
      default: begin
      end
    endcase
    r.rx_level       = LEVEL_W'((DEPTH + rx_wr_idx - rx_rd_idx) % DEPTH);
    r.tx_level       = LEVEL_W'((DEPTH + tx_wr_idx - tx_rd_idx) % DEPTH);
    r.tx_irq_enabled = irq_en;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    errors++;
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, results_seen, what, got, want);
  endtask

  task automatic queue_event(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] data,
                             int unsigned gap);
    ring_event_t ev;
    ev.cmd  = cmd;
    ev.data = data;
    ev.gap  = gap;
    pending_events.push_back(ev);
    total_events++;
  endtask

  function automatic int unsigned draw_gap();
    return $urandom_range(0, 5);
  endfunction

  // driver: presents queued events, waiting each event's gap first
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) begin
        awaited_results.push_back(ring_event_outcome(req.cmd, req.data_in));
        accepted++;
        if (pending_events.size() != 0) gap_left = pending_events[0].gap;
      end
      if (gap_left != 0 || pending_events.size() == 0) begin
        if (gap_left != 0) gap_left--;
        req.valid <= 1'b0;
      end else begin
        req.valid   <= 1'b1;
        req.cmd     <= pending_events[0].cmd;
        req.data_in <= pending_events[0].data;
        void'(pending_events.pop_front());
      end
    end
  end

  // monitor: checks each result transaction and stalls at random
  always @(posedge clk_i) begin
    ring_result_t want;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with nothing awaited, data_out", rsp.data_out, 0);
        end else begin
          want = awaited_results.pop_front();
          if (rsp.data_out !== want.data_out)
            report_mismatch("data_out", rsp.data_out, want.data_out);
          if (rsp.data_valid !== want.data_valid)
            report_mismatch("data_valid", rsp.data_valid, want.data_valid);
          if (rsp.status !== want.status)
            report_mismatch("status", rsp.status, want.status);
          if (rsp.rx_level !== want.rx_level)
            report_mismatch("rx_level", rsp.rx_level, want.rx_level);
          if (rsp.tx_level !== want.tx_level)
            report_mismatch("tx_level", rsp.tx_level, want.tx_level);
          if (rsp.tx_irq_enabled !== want.tx_irq_enabled)
            report_mismatch("tx_irq_enabled", rsp.tx_irq_enabled, want.tx_irq_enabled);
        end
        // switch between stalling and free-running stretches now and then
        if (results_seen % 50 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
        stall_left = rsp_quiet ? 0 : draw_gap();
      end else if (stall_left != 0) begin
        stall_left--;
      end
      rsp.ready <= (stall_left == 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results awaited",
               cycles, awaited_results.size());
      $display("uart_rx_tx_ring_fifo_tb NOT OK");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    seg_mode_e         mode;
    int unsigned       seg;
    int unsigned       seg_len;
    int unsigned       n_random;
    int unsigned       pick;
    bit                quiet;
    logic [CMD_W-1:0]  cmd;
    logic [CMD_W-1:0]  noise;
    logic [BYTE_W-1:0] data;

    req.valid   = 1'b0;
    req.cmd     = CMD_RX_BYTE;
    req.data_in = '0;
    rsp.ready   = 1'b0;

    foreach (rx_bytes[i]) rx_bytes[i] = '0;
    foreach (tx_bytes[i]) tx_bytes[i] = '0;
    rx_wr_idx = 0;
    rx_rd_idx = 0;
    tx_wr_idx = 0;
    tx_rd_idx = 0;
    irq_en    = 1'b0;

    // directed: empty rings first, then byte extremes, peek, flush, spares
    queue_event(CMD_HOST_READ,  8'h00, draw_gap());
    queue_event(CMD_HOST_PEEK,  8'hFF, draw_gap());
    queue_event(CMD_TX_READY,   8'h00, draw_gap());
    queue_event(CMD_RX_BYTE,    8'h00, draw_gap());
    queue_event(CMD_RX_BYTE,    8'hFF, draw_gap());
    queue_event(CMD_RX_BYTE,    8'hA5, draw_gap());
    queue_event(CMD_HOST_PEEK,  8'h00, draw_gap());
    queue_event(CMD_HOST_READ,  8'h00, draw_gap());
    queue_event(CMD_HOST_READ,  8'h00, draw_gap());
    queue_event(CMD_FLUSH,      8'h00, draw_gap());
    queue_event(CMD_HOST_READ,  8'h00, draw_gap());
    queue_event(CMD_HOST_WRITE, 8'hFF, draw_gap());
    queue_event(CMD_HOST_WRITE, 8'h00, draw_gap());
    queue_event(CMD_HOST_WRITE, 8'h5A, draw_gap());
    queue_event(CMD_TX_READY,   8'hFF, draw_gap());
    queue_event(CMD_TX_READY,   8'h00, draw_gap());
    queue_event(CMD_TX_READY,   8'h00, draw_gap());
    queue_event(CMD_TX_READY,   8'h00, draw_gap());
    queue_event(CMD_SPARE_LO,   8'hFF, draw_gap());
    queue_event(CMD_SPARE_HI,   8'h00, draw_gap());
    queue_event(CMD_FLUSH,      8'hFF, draw_gap());

    // random phases: fill and drain each ring so both full cases are reached
    seg      = 0;
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      mode  = seg_mode_e'(seg % 5);
      seg++;
      quiet = ($urandom_range(0, 3) == 0);
      case (mode)
        SEG_RX_FILL, SEG_TX_FILL: seg_len = $urandom_range(70, 90);
        SEG_MIXED:                seg_len = $urandom_range(30, 60);
        default:                  seg_len = $urandom_range(40, 70);
      endcase
      repeat (seg_len) begin
        pick  = $urandom_range(0, 99);
        data  = BYTE_W'($urandom_range(0, 255));
        noise = CMD_W'($urandom_range(0, 7));
        case (mode)
          SEG_RX_FILL: begin
            noise = CMD_W'($urandom_range(1, 4));
            cmd   = (pick < 90) ? CMD_RX_BYTE : noise;
          end
          SEG_RX_DRAIN: begin
            cmd = (pick < 65) ? CMD_HOST_READ : (pick < 80) ? CMD_HOST_PEEK : noise;
          end
          SEG_TX_FILL: begin
            cmd = (pick < 90) ? CMD_HOST_WRITE : noise;
          end
          SEG_TX_DRAIN: begin
            cmd = (pick < 80) ? CMD_TX_READY : noise;
          end
          default: begin
            cmd = noise;
          end
        endcase
        queue_event(cmd, data, quiet ? 0 : draw_gap());
        n_random++;
      end
    end

    // reset
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: every event taken and every result checked
    while (accepted != total_events || awaited_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("uart_rx_tx_ring_fifo_tb OK");
    end else begin
      $display("uart_rx_tx_ring_fifo_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/urtf_pkg.sv
sv/urtf_if.sv
sv/urtf_ring.sv
sv/uart_rx_tx_ring_fifo.sv
dv/uart_rx_tx_ring_fifo_tb.sv
